/* rtl/ordered_sequence_table_assert.svh */
// assertion helpers for the sequence table checks
// both expect clk and rst_n to be visible where they are used
`ifndef ORDERED_SEQUENCE_TABLE_ASSERT_SVH
`define ORDERED_SEQUENCE_TABLE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define OST_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// when pre holds, post must hold in the same cycle
`define OST_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

/* rtl/ost_pkg.sv */
`default_nettype none

package ost_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int FPOS_W  = 8;
    localparam int CNT_W   = 7;

    // -1 in the eight bit position field
    localparam logic [FPOS_W-1:0] FPOS_NONE = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_SORTED = 3'd1,
        CMD_ERASE  = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_GET    = 3'd4,
        CMD_SET    = 3'd5,
        CMD_FIND   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_GET,
        ST_PUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_value;
        logic [FPOS_W-1:0] found_position;
        logic [CNT_W-1:0]  removed_count;
        logic [CNT_W-1:0]  item_count;
    } result_t;

endpackage

`default_nettype wire

/* rtl/ost_result_buf.sv */
`default_nettype none

module ost_result_buf
    import ost_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire result_t push_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // single result slot, refilled in the cycle it drains
    assign push_ready = !valid_reg || out_ready;
    assign valid_next = push_valid ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/ordered_sequence_table.sv */
// ordered sequence table: a positional list of up to DEPTH unsigned values kept packed at
// the low addresses of one memory with one read and one write port and a registered read.
// each request carries a command (insert at position, sorted insert, erase, remove all
// equal, get, set, find) and returns exactly one result with ok and the entry count after
// the command. one request is worked at a time; a new one is taken as soon as the previous
// result sits in the output register, even if nobody has collected it yet. the cost is set
// by the memory walk, one entry per cycle: get and set touch a single entry, insert at
// position p moves the entries from p up by one place, last entry first, erase at p moves
// the entries above p down by one place (erase of the last entry moves none), find stops
// at its first hit or walks the whole list when there is none, sorted insert scans and
// then opens the gap (no gap when the value goes at the end), remove all equal walks the
// whole list. entries need no clearing after reset: only positions below the count are
// ever read.
`default_nettype none

`include "ordered_sequence_table_assert.svh"

module ordered_sequence_table
    import ost_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic [DATA_W-1:0]        item_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          ok,
    output logic [DATA_W-1:0]             read_value,
    output logic signed [FPOS_W-1:0]      found_position,
    output logic [CNT_W-1:0]              removed_count,
    output logic [CNT_W-1:0]              item_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // entry storage
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    // control state
    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   rd_more_reg, rd_more_next;
    logic                   dv_reg, dv_next;

    // request and walk bookkeeping
    cmd_t                   cmd_reg, cmd_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]          rd_end_reg, rd_end_next;
    logic                   rd_up_reg, rd_up_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          wptr_reg, wptr_next;
    logic [AW-1:0]          ins_pos_reg, ins_pos_next;

    // result under construction
    logic                   res_ok_reg, res_ok_next;
    logic [DATA_W-1:0]      res_rdval_reg, res_rdval_next;
    logic [FPOS_W-1:0]      res_fpos_reg, res_fpos_next;
    logic [CW-1:0]          res_removed_reg, res_removed_next;

    logic                   issue;
    logic                   last_data;
    logic                   hit_eq;
    logic                   hit_ge;
    logic [CMPW-1:0]        pos_w;
    logic [CMPW-1:0]        cnt_w;
    logic                   full;

    logic                   push_valid;
    logic                   push_ready;
    result_t                push_data;
    result_t                out_data;

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign pos_w     = CMPW'(pos_reg);
    assign cnt_w     = CMPW'(count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    // data returning this cycle belongs to entry idx_reg
    assign last_data = dv_reg && (idx_reg == rd_end_reg);
    assign hit_eq    = (rd_data_reg == val_reg);
    assign hit_ge    = (rd_data_reg >= val_reg);

    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_more_next     = rd_more_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        rd_ptr_next      = rd_ptr_reg;
        rd_end_next      = rd_end_reg;
        rd_up_next       = rd_up_reg;
        idx_next         = rd_ptr_reg;
        wptr_next        = wptr_reg;
        ins_pos_next     = ins_pos_reg;
        res_ok_next      = res_ok_reg;
        res_rdval_next   = res_rdval_reg;
        res_fpos_next    = res_fpos_reg;
        res_removed_next = res_removed_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = val_reg;
        rd_addr          = rd_ptr_reg;
        push_valid       = 1'b0;

        // streaming read, one entry per cycle toward rd_end
        issue = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT_UP)) && rd_more_reg;
        rd_en = issue;
        if (issue)
        begin
            rd_ptr_next  = rd_up_reg ? (rd_ptr_reg + AW'(1)) : (rd_ptr_reg - AW'(1));
            rd_more_next = (rd_ptr_reg != rd_end_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = cmd_t'(command);
                    pos_next         = position;
                    val_next         = VALUE_WIDTH'(item_value);
                    res_ok_next      = 1'b0;
                    res_rdval_next   = '0;
                    res_fpos_next    = '0;
                    res_removed_next = '0;
                    state_next       = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_DONE;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if ((pos_w <= cnt_w) && !full)
                        begin
                            ins_pos_next = AW'(pos_reg);
                            if (pos_w == cnt_w)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                // move the tail up one place, last entry first
                                rd_ptr_next  = AW'(count_reg - CW'(1));
                                rd_end_next  = AW'(pos_reg);
                                rd_up_next   = 1'b0;
                                rd_more_next = 1'b1;
                                state_next   = ST_SHIFT_UP;
                            end
                        end
                    end
                    CMD_SORTED:
                    begin
                        if (full)
                        begin
                            res_fpos_next = FPOS_NONE;
                        end
                        else if (count_reg == '0)
                        begin
                            ins_pos_next = '0;
                            state_next   = ST_PUT;
                        end
                        else
                        begin
                            rd_ptr_next  = '0;
                            rd_end_next  = AW'(count_reg - CW'(1));
                            rd_up_next   = 1'b1;
                            rd_more_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    CMD_ERASE:
                    begin
                        if (pos_w < cnt_w)
                        begin
                            if ((pos_w + CMPW'(1)) == cnt_w)
                            begin
                                // last entry: nothing to move
                                count_next  = count_reg - CW'(1);
                                res_ok_next = 1'b1;
                            end
                            else
                            begin
                                rd_ptr_next  = AW'(pos_w + CMPW'(1));
                                rd_end_next  = AW'(count_reg - CW'(1));
                                rd_up_next   = 1'b1;
                                rd_more_next = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        wptr_next = '0;
                        if (count_reg == '0)
                        begin
                            res_ok_next = 1'b1;
                        end
                        else
                        begin
                            rd_ptr_next  = '0;
                            rd_end_next  = AW'(count_reg - CW'(1));
                            rd_up_next   = 1'b1;
                            rd_more_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    CMD_GET:
                    begin
                        if (pos_w < cnt_w)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(pos_reg);
                            state_next = ST_GET;
                        end
                    end
                    CMD_SET:
                    begin
                        if (pos_w < cnt_w)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = AW'(pos_reg);
                            res_ok_next = 1'b1;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            res_ok_next   = 1'b1;
                            res_fpos_next = FPOS_NONE;
                        end
                        else
                        begin
                            rd_ptr_next  = '0;
                            rd_end_next  = AW'(count_reg - CW'(1));
                            rd_up_next   = 1'b1;
                            rd_more_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (dv_reg)
                begin
                    unique case (cmd_reg)
                        CMD_SORTED:
                        begin
                            if (hit_ge)
                            begin
                                // insertion point found, open the gap from the top
                                ins_pos_next = idx_reg;
                                rd_ptr_next  = AW'(count_reg - CW'(1));
                                rd_end_next  = idx_reg;
                                rd_up_next   = 1'b0;
                                rd_more_next = 1'b1;
                                state_next   = ST_SHIFT_UP;
                            end
                            else if (last_data)
                            begin
                                ins_pos_next = AW'(count_reg);
                                state_next   = ST_PUT;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (hit_eq)
                            begin
                                res_ok_next   = 1'b1;
                                res_fpos_next = FPOS_W'(idx_reg);
                                state_next    = ST_DONE;
                            end
                            else if (last_data)
                            begin
                                res_ok_next   = 1'b1;
                                res_fpos_next = FPOS_NONE;
                                state_next    = ST_DONE;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            // compaction: keepers go to the write pointer, behind the reads
                            if (hit_eq)
                            begin
                                res_removed_next = res_removed_reg + CW'(1);
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = AW'(wptr_reg);
                                wr_data   = rd_data_reg;
                                wptr_next = wptr_reg + CW'(1);
                            end
                            if (last_data)
                            begin
                                count_next  = hit_eq ? wptr_reg : (wptr_reg + CW'(1));
                                res_ok_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                        end
                        CMD_ERASE:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = idx_reg - AW'(1);
                            wr_data = rd_data_reg;
                            if (last_data)
                            begin
                                count_next  = count_reg - CW'(1);
                                res_ok_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SHIFT_UP:
            begin
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg + AW'(1);
                    wr_data = rd_data_reg;
                    if (last_data)
                    begin
                        state_next = ST_PUT;
                    end
                end
            end

            ST_GET:
            begin
                res_ok_next    = 1'b1;
                res_rdval_next = DATA_W'(rd_data_reg);
                state_next     = ST_DONE;
            end

            ST_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = ins_pos_reg;
                wr_data     = val_reg;
                count_next  = count_reg + CW'(1);
                res_ok_next = 1'b1;
                if (cmd_reg == CMD_SORTED)
                begin
                    res_fpos_next = FPOS_W'(ins_pos_reg);
                end
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a read still in flight when the walk changes phase is dropped
        dv_next = issue && (state_next == state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_more_reg <= 1'b0;
            dv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_more_reg <= rd_more_next;
            dv_reg      <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        rd_ptr_reg      <= rd_ptr_next;
        rd_end_reg      <= rd_end_next;
        rd_up_reg       <= rd_up_next;
        idx_reg         <= idx_next;
        wptr_reg        <= wptr_next;
        ins_pos_reg     <= ins_pos_next;
        res_ok_reg      <= res_ok_next;
        res_rdval_reg   <= res_rdval_next;
        res_fpos_reg    <= res_fpos_next;
        res_removed_reg <= res_removed_next;
    end

    // finished result, count taken after the command's update
    always_comb
    begin
        push_data.ok             = res_ok_reg;
        push_data.read_value     = res_rdval_reg;
        push_data.found_position = res_fpos_reg;
        push_data.removed_count  = CNT_W'(res_removed_reg);
        push_data.item_count     = CNT_W'(count_reg);
    end

    // output register lets the next request start while this result waits
    ost_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign ok             = out_data.ok;
    assign read_value     = out_data.read_value;
    assign found_position = out_data.found_position;
    assign removed_count  = out_data.removed_count;
    assign item_count     = out_data.item_count;

    // the walk never reads the entry it writes in the same cycle
    `OST_ASSERT_IMPL(a_no_rw_overlap, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one entry")
    // count stays within the storage
    `OST_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "entry count beyond depth")
    // the gap is only opened when there is room for one more entry
    `OST_ASSERT_IMPL(a_shift_room, state_reg == ST_SHIFT_UP, count_reg < CW'(DEPTH), "shift up in a full table")
    // an idle table leaves the memory alone
    `OST_ASSERT_IMPL(a_idle_quiet, state_reg == ST_IDLE, !wr_en, "memory written while idle")

endmodule

`default_nettype wire
